>>> rtl/max_heap_priority_queue_assert.svh
// Assertion macros for the max-heap priority queue.
`ifndef MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// Condition that holds at every clock edge outside reset.
`define MHPQ_ASSERT_ALWAYS(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Antecedent in this cycle implies consequent in the next cycle.
`define MHPQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MHPQ_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> rtl/mhpq_pkg.sv
// Shared types and codes of the max-heap priority queue.
`default_nettype none
package mhpq_pkg;

	localparam int unsigned ValW = 31;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic            op;
		logic [ValW-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [ValW-1:0] popped_value;
		logic [1:0]      status;
	} rsp_t;

endpackage
`default_nettype wire

>>> rtl/mhpq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module mhpq_ram #(
	parameter int unsigned WIDTH = 31,
	parameter int unsigned DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> rtl/max_heap_priority_queue.sv
// Binary max-heap priority queue: push or pop one word at a time, heap held in one RAM.
// One command word is taken at a time and answered with one response word. The heap lives
// in a single RAM with one write and one read port and registered read data, and that
// read port sets the pace: a push climbs one level at a time and a pop sinks one level at
// a time. A pop on an empty heap or a push on a full one is answered with status empty or
// full and leaves the heap as is. The queue is idle again once the response is raised,
// ready for the next command word.
// Among equal children the left one is taken; a node only moves past a strictly smaller one.
// A finished response waits in an output register, so the next command is taken while it
// is still stalled. No clearing pass is needed after reset.
`default_nettype none
module max_heap_priority_queue #(
	parameter int unsigned HEAP_DEPTH = 1024
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_stall,
	input  wire mhpq_pkg::cmd_t cmd,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output mhpq_pkg::rsp_t     rsp
);

	import mhpq_pkg::*;

	localparam int unsigned CW = $clog2(HEAP_DEPTH + 1);
	localparam int unsigned AW = $clog2(HEAP_DEPTH);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_UP       = 9'b000000010,
		S_UP_CMP   = 9'b000000100,
		S_POP_TOP  = 9'b000001000,
		S_POP_LAST = 9'b000010000,
		S_POP_LOAD = 9'b000100000,
		S_DN       = 9'b001000000,
		S_DN_R     = 9'b010000000,
		S_RESULT   = 9'b100000000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   node_q;
	logic [ValW-1:0] val_q;
	logic [ValW-1:0] top_q;
	logic [ValW-1:0] left_q;
	logic [1:0]      res_status_q;
	logic            rsp_valid_q;
	rsp_t            rsp_q;

	logic            cmd_acc;
	logic            rsp_free;
	logic            is_full;
	logic            is_empty;
	logic [CW-1:0]   parent;
	logic [CW:0]     child;
	logic [CW:0]     count_ext;
	logic            has_child;
	logic            has_right;
	logic            use_right;
	logic [ValW-1:0] cv;
	logic [CW-1:0]   cnode;
	logic [CW-1:0]   node_m1;
	logic [CW:0]     child_m1;
	logic [CW-1:0]   parent_m1;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [ValW-1:0] ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [ValW-1:0] ram_rdata;

	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc   = cmd_valid && !cmd_stall;
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign is_full   = (count_q == CW'(HEAP_DEPTH));
	assign is_empty  = (count_q == '0);

	assign parent    = node_q >> 1;
	assign parent_m1 = parent - 1'b1;
	assign node_m1   = node_q - 1'b1;
	assign child     = {node_q, 1'b0};
	assign child_m1  = child - 1'b1;
	assign count_ext = {1'b0, count_q};
	assign has_child = (child <= count_ext);
	assign has_right = (child < count_ext);
	// ram_rdata holds the right child in S_DN_R's successor, left_q the left one
	assign use_right = has_right && (left_q < ram_rdata);
	assign cv        = use_right ? ram_rdata : left_q;
	assign cnode     = use_right ? (child[CW-1:0] | CW'(1)) : child[CW-1:0];

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = node_m1[AW-1:0];
		ram_wdata = val_q;
		ram_raddr = '0;
		case (state_q)
			S_UP: begin
				if (node_q == CW'(1)) begin
					ram_we = 1'b1;
				end else begin
					ram_raddr = parent_m1[AW-1:0];
				end
			end
			S_UP_CMP: begin
				ram_we = 1'b1;
				if (val_q > ram_rdata) begin
					ram_wdata = ram_rdata;
				end
			end
			S_POP_TOP: begin
				ram_raddr = '0;
			end
			S_POP_LAST: begin
				ram_raddr = count_q[AW-1:0];
			end
			S_DN: begin
				if (has_child) begin
					ram_raddr = child_m1[AW-1:0];
				end else begin
					ram_we = 1'b1;
				end
			end
			S_DN_R: begin
				ram_raddr = child[AW-1:0];
			end
			default: begin
			end
		endcase
	end

	// the compare step of a sink reuses state S_DN with the flag dn_cmp_q set
	logic dn_cmp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
			dn_cmp_q    <= 1'b0;
		end else begin
			if (rsp_valid_q && !rsp_stall && (state_q != S_RESULT)) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						if (cmd.op == OP_PUSH) begin
							if (is_full) begin
								state_q <= S_RESULT;
							end else begin
								count_q <= count_q + 1'b1;
								state_q <= S_UP;
							end
						end else begin
							if (is_empty) begin
								state_q <= S_RESULT;
							end else begin
								count_q <= count_q - 1'b1;
								state_q <= S_POP_TOP;
							end
						end
					end
				end
				S_UP: begin
					state_q <= (node_q == CW'(1)) ? S_RESULT : S_UP_CMP;
				end
				S_UP_CMP: begin
					state_q <= (val_q > ram_rdata) ? S_UP : S_RESULT;
				end
				S_POP_TOP:  state_q <= S_POP_LAST;
				S_POP_LAST: state_q <= S_POP_LOAD;
				S_POP_LOAD: begin
					dn_cmp_q <= 1'b0;
					state_q  <= S_DN;
				end
				S_DN: begin
					if (dn_cmp_q) begin
						// compare step: sink below the larger child or settle here
						dn_cmp_q <= 1'b0;
						if (val_q >= cv) begin
							state_q <= S_RESULT;
						end
					end else begin
						state_q <= has_child ? S_DN_R : S_RESULT;
					end
				end
				S_DN_R: begin
					dn_cmp_q <= 1'b1;
					state_q  <= S_DN;
				end
				S_RESULT: begin
					if (rsp_free) begin
						rsp_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				val_q <= cmd.value;
				top_q <= '0;
				if (cmd.op == OP_PUSH) begin
					node_q       <= count_q + 1'b1;
					res_status_q <= is_full ? ST_FULL : ST_OK;
				end else begin
					node_q       <= CW'(1);
					res_status_q <= is_empty ? ST_EMPTY : ST_OK;
				end
			end
			S_UP_CMP: begin
				if (val_q > ram_rdata) begin
					node_q <= parent;
				end
			end
			S_POP_LAST: top_q <= ram_rdata;
			S_POP_LOAD: begin
				val_q  <= ram_rdata;
				node_q <= CW'(1);
			end
			S_DN: begin
				if (dn_cmp_q && (val_q < cv)) begin
					node_q <= cnode;
				end
			end
			S_DN_R: left_q <= ram_rdata;
			S_RESULT: begin
				if (rsp_free) begin
					rsp_q.popped_value <= top_q;
					rsp_q.status       <= res_status_q;
				end
			end
			default: begin
			end
		endcase
	end

	logic            we_mux;
	logic [AW-1:0]   waddr_mux;
	logic [ValW-1:0] wdata_mux;
	logic [AW-1:0]   raddr_mux;

	// in the compare step of a sink, write the hole and read nothing
	always_comb begin
		we_mux    = ram_we;
		waddr_mux = ram_waddr;
		wdata_mux = ram_wdata;
		raddr_mux = ram_raddr;
		if ((state_q == S_DN) && dn_cmp_q) begin
			raddr_mux = '0;
			waddr_mux = node_m1[AW-1:0];
			if (val_q >= cv) begin
				we_mux    = 1'b1;
				wdata_mux = val_q;
			end else begin
				we_mux    = 1'b1;
				wdata_mux = cv;
			end
		end
	end

	mhpq_ram #(
		.WIDTH(ValW),
		.DEPTH(HEAP_DEPTH)
	) u_heap_ram (
		.clk  (clk),
		.we   (we_mux),
		.waddr(waddr_mux),
		.wdata(wdata_mux),
		.raddr(raddr_mux),
		.rdata(ram_rdata)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`include "max_heap_priority_queue_assert.svh"

	`MHPQ_ASSERT_ALWAYS(a_count_bound, count_q <= CW'(HEAP_DEPTH), "element count past depth")
	`MHPQ_ASSERT_NEXT(a_push_count, cmd_acc && (cmd.op == OP_PUSH) && !is_full, count_q == $past(count_q) + 1'b1, "accepted push did not grow the heap")
	`MHPQ_ASSERT_IMPL(a_empty_zero, rsp_valid && (rsp.status != ST_OK), rsp.popped_value == '0, "failed command carries a value")

endmodule
`default_nettype wire
